[hdl/steq_pkg.sv]
`default_nettype none

package steq_pkg;

    // Queue geometry and field widths.
    localparam int DEPTH    = 8;
    localparam int TIME_W   = 32;
    localparam int ID_W     = 8;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);

    // Command codes on the input channel.
    localparam logic [CMD_W-1:0] CMD_SCHEDULE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESCHEDULE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EXPIRE     = 2'd2;

    // Status codes on the output channel.
    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EXPIRED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NONE     = 3'd4;

    // Datapath operations issued by the controller.
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NOP        = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD       = 4'd1;
    localparam logic [OP_W-1:0] OP_INS_INIT   = 4'd2;
    localparam logic [OP_W-1:0] OP_INS_SHIFT  = 4'd3;
    localparam logic [OP_W-1:0] OP_INS_PUT    = 4'd4;
    localparam logic [OP_W-1:0] OP_PTR_CLR    = 4'd5;
    localparam logic [OP_W-1:0] OP_FIND_NEXT  = 4'd6;
    localparam logic [OP_W-1:0] OP_REM_SHIFT  = 4'd7;
    localparam logic [OP_W-1:0] OP_REM_DONE   = 4'd8;
    localparam logic [OP_W-1:0] OP_EXP_STEP   = 4'd9;
    localparam logic [OP_W-1:0] OP_SHIFT_STEP = 4'd10;
    localparam logic [OP_W-1:0] OP_SHIFT_DONE = 4'd11;
    localparam logic [OP_W-1:0] OP_EMIT       = 4'd12;

    // Slot read address selection.
    localparam int RD_W = 2;
    localparam logic [RD_W-1:0] RD_PREV  = 2'd0;
    localparam logic [RD_W-1:0] RD_CUR   = 2'd1;
    localparam logic [RD_W-1:0] RD_NEXT  = 2'd2;
    localparam logic [RD_W-1:0] RD_SHIFT = 2'd3;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [RD_W-1:0]     rd_sel;
        logic [STATUS_W-1:0] code;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             ins_stop;
        logic             find_end;
        logic             find_hit;
        logic             rem_end;
        logic             exp_hit;
        logic             shift_end;
        logic             npop_zero;
        logic             out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

[hdl/sorted_timer_event_queue.sv]
`default_nettype none

// Channel   Handshake                Beat payload
// input     in_valid / in_stall      cmd, event_id, time_stamp
// output    out_valid / out_stall    status, out_event_id, out_event_time, last
//
// Commands run one at a time; in_stall is high from acceptance until the
// sequencer returns to idle. A schedule is paced by the one-slot-per-cycle
// shift of the insertion walk; a reschedule does a search and a gap close that
// together cover the queue once, then the insert; an expire does a pop scan,
// then a shift down. Each also waits while out_stall holds a beat. rst_n clears
// the queue to empty with no clearing pass. The output register lets a new
// command start while the last beat of the previous one still waits.

module sorted_timer_event_queue
    import steq_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [CMD_W-1:0]      cmd,
    input  wire logic [ID_W-1:0]       event_id,
    input  wire logic [TIME_W-1:0]     time_stamp,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [STATUS_W-1:0]        status,
    output logic [ID_W-1:0]            out_event_id,
    output logic [TIME_W-1:0]          out_event_time,
    output logic                       last
);

    dp_cmd_t  ctl;
    dp_stat_t stat;

    // Command sequencer.
    steq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .ctl      (ctl)
    );

    // Slot storage, counters and the output register.
    steq_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .stat           (stat),
        .cmd            (cmd),
        .event_id       (event_id),
        .time_stamp     (time_stamp),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .status         (status),
        .out_event_id   (out_event_id),
        .out_event_time (out_event_time),
        .last           (last)
    );

endmodule

`default_nettype wire

[hdl/steq_dpath.sv]
`default_nettype none

module steq_dpath
    import steq_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dp_cmd_t             ctl,
    output dp_stat_t                 stat,
    input  wire logic [CMD_W-1:0]    cmd,
    input  wire logic [ID_W-1:0]     event_id,
    input  wire logic [TIME_W-1:0]   time_stamp,
    input  wire logic                out_stall,
    output logic                     out_valid,
    output logic [STATUS_W-1:0]      status,
    output logic [ID_W-1:0]          out_event_id,
    output logic [TIME_W-1:0]        out_event_time,
    output logic                     last
);

    // Slot storage, sorted by due time from slot 0 upward.
    logic [TIME_W-1:0] slot_time_reg [DEPTH];
    logic [ID_W-1:0]   slot_id_reg   [DEPTH];

    // Control counters.
    logic [CNT_W-1:0] occ_reg,  occ_next;
    logic [CNT_W-1:0] ptr_reg,  ptr_next;
    logic [CNT_W-1:0] npop_reg, npop_next;
    logic             out_valid_reg, out_valid_next;

    // Latched command operands and the pending expired entry.
    logic [CMD_W-1:0]    opc_reg,       opc_next;
    logic [ID_W-1:0]     id_reg,        id_next;
    logic [TIME_W-1:0]   time_reg,      time_next;
    logic [ID_W-1:0]     pend_id_reg,   pend_id_next;
    logic [TIME_W-1:0]   pend_time_reg, pend_time_next;
    logic [STATUS_W-1:0] status_reg,    status_next;
    logic [ID_W-1:0]     oid_reg,       oid_next;
    logic [TIME_W-1:0]   otime_reg,     otime_next;
    logic                last_reg,      last_next;

    logic [CNT_W-1:0]  rd_ptr;
    logic [IDX_W-1:0]  rd_idx;
    logic [TIME_W-1:0] rd_time;
    logic [ID_W-1:0]   rd_id;
    logic [CNT_W-1:0]  shift_sum;
    logic              out_free;
    logic              out_load;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [TIME_W-1:0] wr_time;
    logic [ID_W-1:0]   wr_id;

    // Single slot read port, addressed relative to the scan pointer.
    always_comb
    begin
        case (ctl.rd_sel)
            RD_PREV:  rd_ptr = ptr_reg - CNT_W'(1);
            RD_CUR:   rd_ptr = ptr_reg;
            RD_NEXT:  rd_ptr = ptr_reg + CNT_W'(1);
            RD_SHIFT: rd_ptr = ptr_reg + npop_reg;
            default:  rd_ptr = ptr_reg;
        endcase
    end

    assign rd_idx    = rd_ptr[IDX_W-1:0];
    assign rd_time   = slot_time_reg[rd_idx];
    assign rd_id     = slot_id_reg[rd_idx];
    assign shift_sum = ptr_reg + npop_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // Status toward the controller.
    always_comb
    begin
        stat.cmd       = opc_reg;
        stat.full      = (occ_reg == CNT_W'(DEPTH));
        stat.ins_stop  = (ptr_reg == '0) || (rd_time <= time_reg);
        stat.find_end  = (ptr_reg >= occ_reg);
        stat.find_hit  = (rd_id == id_reg);
        stat.rem_end   = ((ptr_reg + CNT_W'(1)) >= occ_reg);
        stat.exp_hit   = (ptr_reg < occ_reg) && (rd_time < time_reg);
        stat.shift_end = (shift_sum >= occ_reg);
        stat.npop_zero = (npop_reg == '0);
        stat.out_free  = out_free;
    end

    // Operation decode.
    always_comb
    begin
        occ_next       = occ_reg;
        ptr_next       = ptr_reg;
        npop_next      = npop_reg;
        opc_next       = opc_reg;
        id_next        = id_reg;
        time_next      = time_reg;
        pend_id_next   = pend_id_reg;
        pend_time_next = pend_time_reg;
        status_next    = status_reg;
        oid_next       = oid_reg;
        otime_next     = otime_reg;
        last_next      = last_reg;
        out_load       = 1'b0;
        wr_en          = 1'b0;
        wr_idx         = ptr_reg[IDX_W-1:0];
        wr_time        = rd_time;
        wr_id          = rd_id;
        case (ctl.op)
            OP_LOAD:
            begin
                opc_next  = cmd;
                id_next   = event_id;
                time_next = time_stamp;
            end
            OP_INS_INIT:
            begin
                ptr_next = occ_reg;
            end
            OP_INS_SHIFT:
            begin
                wr_en    = 1'b1;
                ptr_next = ptr_reg - CNT_W'(1);
            end
            OP_INS_PUT:
            begin
                wr_en    = 1'b1;
                wr_time  = time_reg;
                wr_id    = id_reg;
                occ_next = occ_reg + CNT_W'(1);
            end
            OP_PTR_CLR:
            begin
                ptr_next  = '0;
                npop_next = '0;
            end
            OP_FIND_NEXT:
            begin
                ptr_next = ptr_reg + CNT_W'(1);
            end
            OP_REM_SHIFT:
            begin
                wr_en    = 1'b1;
                ptr_next = ptr_reg + CNT_W'(1);
            end
            OP_REM_DONE:
            begin
                occ_next = occ_reg - CNT_W'(1);
                ptr_next = occ_reg - CNT_W'(1);
            end
            OP_EXP_STEP:
            begin
                // Release the held entry once we know whether another follows.
                if (!stat.npop_zero)
                begin
                    out_load    = 1'b1;
                    status_next = ST_EXPIRED;
                    oid_next    = pend_id_reg;
                    otime_next  = pend_time_reg;
                    last_next   = !stat.exp_hit;
                end
                if (stat.exp_hit)
                begin
                    pend_id_next   = rd_id;
                    pend_time_next = rd_time;
                    ptr_next       = ptr_reg + CNT_W'(1);
                    npop_next      = npop_reg + CNT_W'(1);
                end
                else
                begin
                    ptr_next = '0;
                end
            end
            OP_SHIFT_STEP:
            begin
                wr_en    = 1'b1;
                ptr_next = ptr_reg + CNT_W'(1);
            end
            OP_SHIFT_DONE:
            begin
                occ_next = occ_reg - npop_reg;
            end
            OP_EMIT:
            begin
                out_load    = 1'b1;
                status_next = ctl.code;
                oid_next    = '0;
                otime_next  = '0;
                last_next   = 1'b1;
            end
            default:
            begin
            end
        endcase
        out_valid_next = out_load ? 1'b1 : (out_valid_reg && out_stall);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            ptr_reg       <= '0;
            npop_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg       <= occ_next;
            ptr_reg       <= ptr_next;
            npop_reg      <= npop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        opc_reg       <= opc_next;
        id_reg        <= id_next;
        time_reg      <= time_next;
        pend_id_reg   <= pend_id_next;
        pend_time_reg <= pend_time_next;
        status_reg    <= status_next;
        oid_reg       <= oid_next;
        otime_reg     <= otime_next;
        last_reg      <= last_next;
    end

    // Slot write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_time_reg[wr_idx] <= wr_time;
            slot_id_reg[wr_idx]   <= wr_id;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign out_event_id   = oid_reg;
    assign out_event_time = otime_reg;
    assign last           = last_reg;

endmodule

`default_nettype wire

[hdl/steq_ctrl.sv]
`default_nettype none

module steq_ctrl
    import steq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire dp_stat_t stat,
    output dp_cmd_t       ctl
);

    localparam int S_W = 3;
    localparam logic [S_W-1:0] S_IDLE     = 3'd0;
    localparam logic [S_W-1:0] S_DISPATCH = 3'd1;
    localparam logic [S_W-1:0] S_INSERT   = 3'd2;
    localparam logic [S_W-1:0] S_FIND     = 3'd3;
    localparam logic [S_W-1:0] S_REMOVE   = 3'd4;
    localparam logic [S_W-1:0] S_EXPIRE   = 3'd5;
    localparam logic [S_W-1:0] S_SHIFT    = 3'd6;
    localparam logic [S_W-1:0] S_RESULT   = 3'd7;

    logic [S_W-1:0]      state_reg, state_next;
    logic [STATUS_W-1:0] code_reg,  code_next;

    // Sequencer: the read select follows the state only, the operation may
    // follow datapath status.
    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        ctl.op     = OP_NOP;
        ctl.rd_sel = RD_CUR;
        ctl.code   = code_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.op     = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.cmd)
                    CMD_SCHEDULE:
                    begin
                        if (stat.full)
                        begin
                            code_next  = ST_FULL;
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            ctl.op     = OP_INS_INIT;
                            state_next = S_INSERT;
                        end
                    end
                    CMD_RESCHEDULE:
                    begin
                        ctl.op     = OP_PTR_CLR;
                        state_next = S_FIND;
                    end
                    CMD_EXPIRE:
                    begin
                        ctl.op     = OP_PTR_CLR;
                        state_next = S_EXPIRE;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_INSERT:
            begin
                // Walk down from the tail, moving later entries up one slot.
                ctl.rd_sel = RD_PREV;
                if (stat.ins_stop)
                begin
                    ctl.op     = OP_INS_PUT;
                    code_next  = ST_ACCEPTED;
                    state_next = S_RESULT;
                end
                else
                begin
                    ctl.op = OP_INS_SHIFT;
                end
            end
            S_FIND:
            begin
                ctl.rd_sel = RD_CUR;
                if (stat.find_end)
                begin
                    code_next  = ST_ABSENT;
                    state_next = S_RESULT;
                end
                else if (stat.find_hit)
                begin
                    state_next = S_REMOVE;
                end
                else
                begin
                    ctl.op = OP_FIND_NEXT;
                end
            end
            S_REMOVE:
            begin
                // Close the gap, then insert again from the new tail.
                ctl.rd_sel = RD_NEXT;
                if (stat.rem_end)
                begin
                    ctl.op     = OP_REM_DONE;
                    state_next = S_INSERT;
                end
                else
                begin
                    ctl.op = OP_REM_SHIFT;
                end
            end
            S_EXPIRE:
            begin
                ctl.rd_sel = RD_CUR;
                if (stat.npop_zero || stat.out_free)
                begin
                    ctl.op = OP_EXP_STEP;
                    if (!stat.exp_hit)
                    begin
                        if (stat.npop_zero)
                        begin
                            code_next  = ST_NONE;
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_SHIFT;
                        end
                    end
                end
            end
            S_SHIFT:
            begin
                // Move the surviving entries down over the popped ones.
                ctl.rd_sel = RD_SHIFT;
                if (stat.shift_end)
                begin
                    ctl.op     = OP_SHIFT_DONE;
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.op = OP_SHIFT_STEP;
                end
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    ctl.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
    end

endmodule

`default_nettype wire
